### rtl/srr_pkg.sv
// Shared types and constants of the selective repeat receiver.
package srr_pkg;

    localparam int DEF_WINDOW_SIZE    = 8;
    localparam int DEF_SEQUENCE_SPACE = 16;

    localparam int SEQ_W        = 4;
    localparam int SEQ_COUNT    = 2 ** SEQ_W;
    localparam int CSUM_W       = 32;
    localparam int ACK_CSUM_W   = 10;
    localparam int PAYLOAD_BITS = 160;
    localparam int PAIR_BITS    = 16;
    localparam int PAIR_STEPS   = PAYLOAD_BITS / PAIR_BITS;
    localparam int STEP_W       = $clog2(PAIR_STEPS);

    localparam logic [ACK_CSUM_W-1:0] ACK_CSUM_BASE = 10'd960;

    typedef enum logic {
        KIND_ACK  = 1'b0,
        KIND_DATA = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_CHECK,
        S_ACK,
        S_DELIVER
    } t_state;

    typedef struct packed {
        logic [31:0] top;
        logic [63:0] mid;
        logic [63:0] low;
    } t_payload;

    typedef struct packed {
        logic [SEQ_W-1:0]         seq_number;
        logic signed [CSUM_W-1:0] ack_field;
        logic signed [CSUM_W-1:0] packet_checksum;
        logic [63:0]              payload_low;
        logic [63:0]              payload_mid;
        logic [31:0]              payload_top;
    } t_in_word;

    typedef struct packed {
        t_kind                 kind;
        logic [SEQ_W-1:0]      ack_number;
        logic [ACK_CSUM_W-1:0] ack_checksum;
        logic [63:0]           out_payload_low;
        logic [63:0]           out_payload_mid;
        logic [31:0]           out_payload_top;
        logic                  last;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic step;
    } t_csum_ctl;

endpackage

### rtl/srr_csum_unit.sv
// Shared checksum accumulator: adds two signed payload bytes per cycle while step is set.
module srr_csum_unit (
    input  logic                          i_clk,
    input  srr_pkg::t_csum_ctl            i_ctl,
    input  logic [srr_pkg::SEQ_W-1:0]     i_seq,
    input  logic [srr_pkg::CSUM_W-1:0]    i_ack,
    input  srr_pkg::t_payload             i_payload,
    output logic [srr_pkg::CSUM_W-1:0]    o_acc
);
    import srr_pkg::*;

    logic [CSUM_W-1:0]       r_acc;
    logic [CSUM_W-1:0]       n_acc;
    logic [PAYLOAD_BITS-1:0] r_shift;
    logic [PAYLOAD_BITS-1:0] n_shift;
    logic [CSUM_W-1:0]       byte_lo;
    logic [CSUM_W-1:0]       byte_hi;

    // sign-extend the two bytes at the bottom of the shift register
    assign byte_lo = {{(CSUM_W-8){r_shift[7]}},  r_shift[7:0]};
    assign byte_hi = {{(CSUM_W-8){r_shift[15]}}, r_shift[15:8]};

    always_comb begin
        n_acc   = r_acc;
        n_shift = r_shift;
        if (i_ctl.load) begin
            n_acc   = CSUM_W'(i_seq) + i_ack;
            n_shift = i_payload;
        end else if (i_ctl.step) begin
            n_acc   = r_acc + byte_lo + byte_hi;
            n_shift = r_shift >> PAIR_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_shift <= n_shift;
    end

    assign o_acc = r_acc;

endmodule

### rtl/srr_slot_mem.sv
// Payload store of the receive window, one write and one registered read port.
module srr_slot_mem #(
    parameter int DEPTH  = srr_pkg::DEF_WINDOW_SIZE,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  srr_pkg::t_payload i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output srr_pkg::t_payload o_rd_data
);
    import srr_pkg::*;

    t_payload r_mem [DEPTH];
    t_payload r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/selective_repeat_receiver_top.sv
// Top level of the selective repeat receiver: sequencer, window state and output register.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+---------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_in_word  (t_in_word)
//  out     | from block| o_out_valid / i_out_stall | o_out_word (t_out_word)
//
// One packet holds the input through the load, ten byte-pair additions in the shared
// checksum adder and the check, and then while the ack and up to WINDOW_SIZE deliveries
// go out, paced by the single output register and the memory read.
// A corrupted packet frees the input after the check cycle.
// Reset clears base, slot-full bits and the sequencer; payload store needs no reset.
// A stall on the output holds the result register and pauses the sequencer in S_ACK and S_DELIVER.
module selective_repeat_receiver_top #(
    parameter int WINDOW_SIZE    = srr_pkg::DEF_WINDOW_SIZE,
    parameter int SEQUENCE_SPACE = srr_pkg::DEF_SEQUENCE_SPACE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  srr_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output srr_pkg::t_out_word o_out_word
);
    import srr_pkg::*;

    localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int BASE_W = (SEQUENCE_SPACE > 2) ? $clog2(SEQUENCE_SPACE) : 1;
    localparam int DIST_W = BASE_W + 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PAIR_STEPS - 1);
    localparam logic [BASE_W-1:0] BASE_TOP  = BASE_W'(SEQUENCE_SPACE - 1);
    localparam logic [SLOT_W-1:0] SLOT_TOP  = SLOT_W'(WINDOW_SIZE - 1);
    localparam logic [DIST_W-1:0] SPACE_D   = DIST_W'(SEQUENCE_SPACE);

    // slot of each sequence number, built at elaboration by counting round the window
    function automatic logic [SEQ_COUNT*SLOT_W-1:0] seq_slot_table();
        logic [SEQ_COUNT*SLOT_W-1:0] tbl;
        int                          j;
        tbl = '0;
        j   = 0;
        for (int i = 0; i < SEQ_COUNT; i++) begin
            tbl[i*SLOT_W +: SLOT_W] = SLOT_W'(j);
            j = (j == WINDOW_SIZE - 1) ? 0 : j + 1;
        end
        return tbl;
    endfunction

    localparam logic [SEQ_COUNT*SLOT_W-1:0] SEQ_SLOT = seq_slot_table();

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    t_in_word            r_pkt;
    logic [BASE_W-1:0]   r_base, n_base;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [WINDOW_SIZE-1:0] r_full, n_full;
    logic                r_in_win, n_in_win;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out_word, n_out_word;

    t_csum_ctl           csum_ctl;
    logic [CSUM_W-1:0]   csum_acc;
    t_payload            pkt_payload;
    t_payload            rd_payload;
    logic                accept;
    logic                out_load;
    logic                csum_ok;
    logic                in_space;
    logic [DIST_W-1:0]   dist_raw;
    logic [DIST_W-1:0]   win_dist;
    logic                in_win;
    logic [SLOT_W-1:0]   seq_slot;
    logic [BASE_W-1:0]   adv_base;
    logic [SLOT_W-1:0]   adv_slot;
    logic                more;
    logic                store;
    logic                emit_ack;
    logic                emit_data;
    logic [SLOT_W-1:0]   rd_addr;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_load = !r_out_valid || !i_out_stall;

    assign pkt_payload = '{top: r_pkt.payload_top, mid: r_pkt.payload_mid,
                           low: r_pkt.payload_low};

    // window test: distance from base, wrapped once round the sequence space
    assign csum_ok  = (csum_acc == unsigned'(r_pkt.packet_checksum));
    assign in_space = ({5'd0, r_pkt.seq_number} < 9'(SEQUENCE_SPACE));
    assign dist_raw = DIST_W'(r_pkt.seq_number) + SPACE_D - {1'b0, r_base};
    assign win_dist = (dist_raw >= SPACE_D) ? dist_raw - SPACE_D : dist_raw;
    assign in_win   = in_space && (32'(win_dist) < 32'(WINDOW_SIZE));
    assign seq_slot = SEQ_SLOT[r_pkt.seq_number*SLOT_W +: SLOT_W];

    // base after one delivery; its slot restarts with the base at wrap
    assign adv_base = (r_base == BASE_TOP) ? '0 : r_base + BASE_W'(1);
    assign adv_slot = ((r_base == BASE_TOP) || (r_slot == SLOT_TOP)) ? '0
                                                                     : r_slot + SLOT_W'(1);
    // another delivery follows when the next slot is full and is not the one emptied
    assign more     = r_full[adv_slot] && (adv_slot != r_slot);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SUM;
            end
            S_SUM: begin
                if (r_step == LAST_STEP) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = csum_ok ? S_ACK : S_IDLE;
            end
            S_ACK: begin
                if (out_load) begin
                    n_state = (r_in_win && r_full[r_slot]) ? S_DELIVER : S_IDLE;
                end
            end
            S_DELIVER: begin
                if (out_load && !more) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall    = 1'b1;
        csum_ctl.load = 1'b0;
        csum_ctl.step = 1'b0;
        store         = 1'b0;
        emit_ack      = 1'b0;
        emit_data     = 1'b0;
        n_in_win      = r_in_win;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                csum_ctl.load = accept;
            end
            S_SUM: begin
                csum_ctl.step = 1'b1;
            end
            S_CHECK: begin
                n_in_win = in_win;
                store    = csum_ok && in_win && !r_full[seq_slot];
            end
            S_ACK: begin
                emit_ack = out_load;
            end
            S_DELIVER: begin
                emit_data = out_load;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // window state and result word
    always_comb begin
        n_step      = r_step;
        n_base      = r_base;
        n_slot      = r_slot;
        n_full      = r_full;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        if (accept) begin
            n_step = '0;
        end else if (csum_ctl.step) begin
            n_step = r_step + STEP_W'(1);
        end

        if (store) begin
            n_full[seq_slot] = 1'b1;
        end

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (emit_ack) begin
            n_out_valid                = 1'b1;
            n_out_word                 = '0;
            n_out_word.kind            = KIND_ACK;
            n_out_word.ack_number      = r_pkt.seq_number;
            n_out_word.ack_checksum    = ACK_CSUM_BASE + ACK_CSUM_W'(r_pkt.seq_number);
            n_out_word.last            = !(r_in_win && r_full[r_slot]);
        end

        if (emit_data) begin
            n_out_valid                = 1'b1;
            n_out_word                 = '0;
            n_out_word.kind            = KIND_DATA;
            n_out_word.out_payload_low = rd_payload.low;
            n_out_word.out_payload_mid = rd_payload.mid;
            n_out_word.out_payload_top = rd_payload.top;
            n_out_word.last            = !more;
            n_full[r_slot]             = 1'b0;
            n_base                     = adv_base;
            n_slot                     = adv_slot;
        end
    end

    // read the slot the base will point at, so its payload is ready next cycle
    assign rd_addr = emit_data ? adv_slot : r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_base      <= '0;
            r_slot      <= '0;
            r_full      <= '0;
            r_in_win    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_base      <= n_base;
            r_slot      <= n_slot;
            r_full      <= n_full;
            r_in_win    <= n_in_win;
            r_out_valid <= n_out_valid;
        end
    end

    // hold the packet and the result word; no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pkt <= i_in_word;
        end
        r_out_word <= n_out_word;
    end

    srr_csum_unit u_csum (
        .i_clk     (i_clk),
        .i_ctl     (csum_ctl),
        .i_seq     (i_in_word.seq_number),
        .i_ack     (unsigned'(i_in_word.ack_field)),
        .i_payload ('{top: i_in_word.payload_top, mid: i_in_word.payload_mid,
                      low: i_in_word.payload_low}),
        .o_acc     (csum_acc)
    );

    srr_slot_mem #(
        .DEPTH  (WINDOW_SIZE),
        .ADDR_W (SLOT_W)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (store),
        .i_wr_addr (seq_slot),
        .i_wr_data (pkt_payload),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_payload)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### tb/srr_tb_pkg.sv
// Receive-window predictor and result scoreboard for the selective repeat receiver bench.
package srr_tb_pkg;
    import srr_pkg::*;

    class srr_window_model;
        logic [SEQ_W-1:0] next_base;
        bit               held [DEF_WINDOW_SIZE];
        t_payload         held_payload [DEF_WINDOW_SIZE];
        t_out_word        due_words [$];
        int               bad_words;

        function new();
            next_base = '0;
            foreach (held[i]) held[i] = 1'b0;
            bad_words = 0;
        endfunction

        // Wrapping sum of seq, ack field and the twenty payload bytes taken as signed.
        static function logic [CSUM_W-1:0] packet_sum(t_in_word w);
            logic [PAYLOAD_BITS-1:0] bytes_flat;
            logic [CSUM_W-1:0]       acc;
            logic [7:0]              b;
            bytes_flat = {w.payload_top, w.payload_mid, w.payload_low};
            acc = CSUM_W'(w.seq_number) + CSUM_W'(w.ack_field);
            for (int i = 0; i < PAYLOAD_BITS / 8; i++) begin
                b   = bytes_flat[8*i +: 8];
                acc = acc + {{(CSUM_W-8){b[7]}}, b};
            end
            return acc;
        endfunction

        static function string describe(t_out_word w);
            return $sformatf("kind=%0d ack=%0d csum=%0d low=%h mid=%h top=%h last=%0b",
                             w.kind, w.ack_number, w.ack_checksum, w.out_payload_low,
                             w.out_payload_mid, w.out_payload_top, w.last);
        endfunction

        // Work out the ack and the in-order deliveries that one accepted packet causes.
        function void take_packet(t_in_word w);
            t_out_word word;
            int        win_dist;
            int        slot;
            int        deliveries;
            bit        in_window;
            if (packet_sum(w) != CSUM_W'(w.packet_checksum)) return;
            win_dist = (int'(w.seq_number) + DEF_SEQUENCE_SPACE - int'(next_base))
                       % DEF_SEQUENCE_SPACE;
            in_window = (int'(w.seq_number) < DEF_SEQUENCE_SPACE)
                        && (win_dist < DEF_WINDOW_SIZE);
            slot = int'(w.seq_number) % DEF_WINDOW_SIZE;
            if (in_window && !held[slot]) begin
                held_payload[slot].low = w.payload_low;
                held_payload[slot].mid = w.payload_mid;
                held_payload[slot].top = w.payload_top;
                held[slot]             = 1'b1;
            end
            word              = '0;
            word.kind         = KIND_ACK;
            word.ack_number   = w.seq_number;
            word.ack_checksum = ACK_CSUM_BASE + ACK_CSUM_W'(w.seq_number);
            deliveries = 0;
            while (in_window && deliveries < DEF_WINDOW_SIZE
                   && held[int'(next_base) % DEF_WINDOW_SIZE]) begin
                due_words.push_back(word);
                slot                 = int'(next_base) % DEF_WINDOW_SIZE;
                word                 = '0;
                word.kind            = KIND_DATA;
                word.out_payload_low = held_payload[slot].low;
                word.out_payload_mid = held_payload[slot].mid;
                word.out_payload_top = held_payload[slot].top;
                held[slot]           = 1'b0;
                next_base            = SEQ_W'((int'(next_base) + 1) % DEF_SEQUENCE_SPACE);
                deliveries++;
            end
            word.last = 1'b1;
            due_words.push_back(word);
        endfunction

        function void match_result(t_out_word got);
            t_out_word want;
            if (due_words.size() == 0) begin
                bad_words++;
                if (bad_words <= 10) $display("unexpected result word: %s", describe(got));
                return;
            end
            want = due_words.pop_front();
            if (got.kind !== want.kind || got.ack_number !== want.ack_number
                || got.ack_checksum !== want.ack_checksum
                || got.out_payload_low !== want.out_payload_low
                || got.out_payload_mid !== want.out_payload_mid
                || got.out_payload_top !== want.out_payload_top
                || got.last !== want.last) begin
                bad_words++;
                if (bad_words <= 10) begin
                    $display("result word mismatch, expected %s", describe(want));
                    $display("                       actual %s", describe(got));
                end
            end
        endfunction
    endclass

endpackage

### tb/tb_top.sv
// Top-level bench of the selective repeat receiver: clock, reset, stimulus and checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srr_pkg::*;
    import srr_tb_pkg::*;

    // Payload fill patterns: random bytes or one of the byte extremes.
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_MIN,
        FILL_MAX
    } t_fill;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 5;
    localparam int RANDOM_PER_PHASE = 90;
    // A corrupted packet holds the block through its checksum pass with no result.
    localparam int SETTLE_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT   = 5000;

    // Sequence numbers of the directed part. Starting from base 0: fill slot 3, repeat it,
    // send two packets outside the window, fill the rest and then the base slot so that
    // one packet releases the full window. Then walk the window across the wrap of the
    // sequence space with a gap that is closed out of order.
    localparam int DIRECTED_SEQ [20] = '{3, 3, 8, 15, 7, 6, 5, 4, 2, 1, 0,
                                         8, 0, 15, 12, 9, 10, 11, 13, 14};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    int in_idle_pct   = 24;
    int out_stall_pct = 87;
    int quiet_cycles  = 0;

    srr_window_model rx_model;

    selective_repeat_receiver_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Receiver side: stall at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Check every result word taken from the block against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            rx_model.match_result(o_out_word);
        end
    end

    // Count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Abandon a run that has hung.
    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Build one data packet; a corrupted one has a single checksum bit flipped.
    function automatic t_in_word make_packet(logic [SEQ_W-1:0] seq, logic [CSUM_W-1:0] ack,
                                             bit corrupt, t_fill fill);
        t_in_word                w;
        logic [PAYLOAD_BITS-1:0] bytes_flat;
        case (fill)
            FILL_ZERO: bytes_flat = '0;
            FILL_ONES: bytes_flat = '1;
            FILL_MIN:  bytes_flat = {(PAYLOAD_BITS/8){8'h80}};
            FILL_MAX:  bytes_flat = {(PAYLOAD_BITS/8){8'h7f}};
            default:   bytes_flat = {$urandom, $urandom, $urandom, $urandom, $urandom};
        endcase
        w.seq_number = seq;
        w.ack_field  = ack;
        {w.payload_top, w.payload_mid, w.payload_low} = bytes_flat;
        w.packet_checksum = srr_window_model::packet_sum(w);
        if (corrupt) begin
            w.packet_checksum = w.packet_checksum ^ (CSUM_W'(1) << $urandom_range(CSUM_W-1));
        end
        return w;
    endfunction

    // Offer one word, hold it until taken, then idle at the rate of the current phase.
    task automatic send_word(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        rx_model.take_packet(w);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold the sender back until every expected result word has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (rx_model.due_words.size() != 0);
    endtask

    // Mostly packets inside the current window in random order, so that gaps open and
    // close and deliveries of every length occur; the rest are stale repeats, any
    // sequence number at all, and corrupted packets. Only good packets are counted.
    task automatic run_random(input int good_count);
        int               sent;
        int               pick;
        bit               corrupt;
        logic [SEQ_W-1:0] seq;
        t_fill            fill;
        sent = 0;
        while (sent < good_count) begin
            pick    = $urandom_range(99);
            corrupt = 1'b0;
            // 4-bit arithmetic wraps at the sequence space.
            if (pick < 70) begin
                seq = rx_model.next_base + SEQ_W'($urandom_range(DEF_WINDOW_SIZE-1));
            end else if (pick < 80) begin
                seq = rx_model.next_base - SEQ_W'($urandom_range(DEF_WINDOW_SIZE, 1));
            end else if (pick < 88) begin
                seq = SEQ_W'($urandom_range(SEQ_COUNT-1));
            end else begin
                seq     = SEQ_W'($urandom_range(SEQ_COUNT-1));
                corrupt = 1'b1;
            end
            fill = ($urandom_range(19) == 0) ? t_fill'($urandom_range(FILL_MAX, FILL_ZERO))
                                             : FILL_RANDOM;
            send_word(make_packet(seq, $urandom, corrupt, fill));
            if (!corrupt) sent++;
        end
    endtask

    initial begin
        logic [CSUM_W-1:0] ack;
        rx_model = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles now and then, receiver stalls most of the time.
        in_idle_pct   = 24;
        out_stall_pct = 87;
        send_word(make_packet(SEQ_W'(0), 32'h7fff_ffff, 1'b1, FILL_ONES));
        for (int i = 0; i < 20; i++) begin
            case (i % 4)
                0:       ack = 32'h8000_0000;
                1:       ack = 32'h7fff_ffff;
                2:       ack = '0;
                default: ack = '1;
            endcase
            send_word(make_packet(SEQ_W'(DIRECTED_SEQ[i]), ack, 1'b0, t_fill'(i % 5)));
        end
        send_word(make_packet(SEQ_W'(15), 32'h8000_0000, 1'b1, FILL_MIN));
        drain_results();
        run_random(RANDOM_PER_PHASE);
        drain_results();

        // Phase two: the other way round.
        in_idle_pct   = 87;
        out_stall_pct = 24;
        run_random(RANDOM_PER_PHASE);
        drain_results();

        // Phase three: full rate on both sides.
        in_idle_pct   = 0;
        out_stall_pct = 0;
        run_random(RANDOM_PER_PHASE);
        drain_results();

        // Let a trailing corrupted packet clear and catch any stray result word.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (rx_model.bad_words == 0 && rx_model.due_words.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
